// ===== rtl/core/sls_pkg.sv =====
// Package for the six-LED light show sequencer.
// Holds the transaction payload types, the show state type, mode codes and the step logic.
// Has no dependencies.
`default_nettype none

package sls_pkg;

   localparam logic [15:0] STEP_INTERVAL_RESET = 16'd500;
   localparam logic [4:0]  FLUSH_STEPS         = 5'd12;
   localparam logic [4:0]  LEFT_RIGHT_STEPS    = 5'd8;
   localparam logic [4:0]  CHASE_LAST          = 5'd24;
   localparam logic [2:0]  LED_FIRST           = 3'd1;
   localparam logic [2:0]  LED_LAST            = 3'd6;

   typedef enum logic [1:0] {
      MODE_IDENTIFY   = 2'd0,
      MODE_FLUSH      = 2'd1,
      MODE_LEFT_RIGHT = 2'd2,
      MODE_CHASE      = 2'd3
   } mode_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        restart;
   } req_type;

   typedef struct packed {
      logic [5:0] led_pattern;
      logic [1:0] show_mode;
      logic       stepped;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  lit_leds;
      mode_type    pattern_mode;
      logic [2:0]  active_led;
      logic [4:0]  blink_count;
      logic [31:0] last_step_time;
   } show_state_type;

   localparam show_state_type SHOW_RESET = '{
      lit_leds:       6'd0,
      pattern_mode:   MODE_IDENTIFY,
      active_led:     LED_FIRST,
      blink_count:    5'd0,
      last_step_time: 32'd0
   };

   // Remainder by three of a five-bit count, by compare and subtract.
   function automatic logic [1:0] mod3(input logic [4:0] value);
      logic [4:0] rem;
      rem = value;
      if (rem >= 5'd24) rem = rem - 5'd24;
      if (rem >= 5'd12) rem = rem - 5'd12;
      if (rem >= 5'd6)  rem = rem - 5'd6;
      if (rem >= 5'd3)  rem = rem - 5'd3;
      return rem[1:0];
   endfunction

   // One pattern step in the current mode; the step time is handled by the caller.
   function automatic show_state_type run_step(input show_state_type s);
      show_state_type n;
      logic [5:0]     led_bit;
      logic [4:0]     blink_next;
      n          = s;
      led_bit    = 6'd1 << (s.active_led - 3'd1);
      blink_next = s.blink_count + 5'd1;
      unique case (s.pattern_mode)
         MODE_IDENTIFY: begin
            if (s.active_led >= LED_FIRST && s.active_led <= LED_LAST) begin
               if ((s.lit_leds & led_bit) == 6'd0) begin
                  n.lit_leds = led_bit;
               end else begin
                  n.lit_leds = 6'd0;
                  if (s.blink_count >= {2'd0, s.active_led - 3'd1}) begin
                     n.blink_count = 5'd0;
                     if (s.active_led == LED_LAST) begin
                        n.active_led   = LED_FIRST;
                        n.pattern_mode = MODE_FLUSH;
                     end else begin
                        n.active_led = s.active_led + 3'd1;
                     end
                  end else begin
                     n.blink_count = blink_next;
                  end
               end
            end
         end
         MODE_FLUSH: begin
            unique case (mod3(s.blink_count))
               2'd0:    n.lit_leds = 6'h03;
               2'd1:    n.lit_leds = 6'h0C;
               default: n.lit_leds = 6'h30;
            endcase
            n.blink_count = blink_next;
            if (blink_next >= FLUSH_STEPS) begin
               n.active_led   = LED_FIRST;
               n.blink_count  = 5'd0;
               n.pattern_mode = MODE_LEFT_RIGHT;
            end
         end
         MODE_LEFT_RIGHT: begin
            n.lit_leds    = s.blink_count[0] ? 6'h2A : 6'h15;
            n.blink_count = blink_next;
            if (blink_next >= LEFT_RIGHT_STEPS) begin
               n.active_led   = LED_FIRST;
               n.blink_count  = 5'd0;
               n.pattern_mode = MODE_CHASE;
            end
         end
         MODE_CHASE: begin
            unique case (s.active_led)
               3'd1: begin
                  n.lit_leds   = 6'h01;
                  n.active_led = 3'd3;
               end
               3'd3: begin
                  n.lit_leds   = 6'h04;
                  n.active_led = 3'd5;
               end
               3'd5: begin
                  n.lit_leds   = 6'h10;
                  n.active_led = 3'd6;
               end
               3'd6: begin
                  n.lit_leds   = 6'h20;
                  n.active_led = 3'd4;
               end
               3'd4: begin
                  n.lit_leds   = 6'h08;
                  n.active_led = 3'd2;
               end
               default: begin
                  n.lit_leds   = 6'h02;
                  n.active_led = 3'd1;
               end
            endcase
            if (s.blink_count >= CHASE_LAST) begin
               n.lit_leds     = 6'd0;
               n.active_led   = LED_FIRST;
               n.blink_count  = 5'd0;
               n.pattern_mode = MODE_IDENTIFY;
            end else begin
               n.blink_count = blink_next;
            end
         end
         default: n = s;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/six_led_light_show_sequencer.sv =====
// Top level of the six-LED light show sequencer: input register, step logic, result register.
// Depends on sls_pkg for payload types, mode codes and the step function.
`default_nettype none

// Each request transaction is a tick carrying the millisecond time. The block answers every tick
// with one response transaction holding the LED pattern, the show mode and whether the pattern
// advanced. A tick is taken every cycle unless req_stall holds it: it waits in the input register,
// and the response is registered in the result register when the output is not stalled, so the
// throughput is one tick per cycle while rsp_stall is low. The interval register is written
// through the csr port, which is always ready.
module six_led_light_show_sequencer
   import sls_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [15:0] csr_data
);

   logic           in_valid_ff;
   req_type        in_data_ff;
   logic           out_valid_ff;
   rsp_type        out_data_ff;
   show_state_type state_ff;
   show_state_type state_in;
   logic [15:0]    interval_ff;
   logic [15:0]    interval;
   logic [31:0]    elapsed;
   logic           due;
   logic           stepped;
   logic           cascade;
   logic           advance;
   show_state_type first_step;
   show_state_type stepped_state;
   rsp_type        out_data_in;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      interval      = (state_ff.pattern_mode == MODE_CHASE) ? {1'b0, interval_ff[15:1]}
                                                             : interval_ff;
      elapsed       = in_data_ff.now_ms - state_ff.last_step_time;
      due           = (state_ff.last_step_time == 32'd0) || (elapsed > {16'd0, interval});
      first_step    = run_step(state_ff);
      first_step.last_step_time = in_data_ff.now_ms;
      cascade       = (in_data_ff.now_ms == 32'd0)
                      && (first_step.pattern_mode > state_ff.pattern_mode);
      stepped_state = cascade ? run_step(first_step) : first_step;
      if (in_data_ff.restart) begin
         state_in = SHOW_RESET;
         stepped  = 1'b0;
      end else if (due) begin
         state_in = stepped_state;
         stepped  = 1'b1;
      end else begin
         state_in = state_ff;
         stepped  = 1'b0;
      end
      out_data_in.led_pattern = state_in.lit_leds;
      out_data_in.show_mode   = state_in.pattern_mode;
      out_data_in.stepped     = stepped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= SHOW_RESET;
         interval_ff  <= STEP_INTERVAL_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            interval_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire
